@@ hw/rtl/c3r_pkg.sv @@
// c3r_pkg: shared constants, register and command codes, beat types and the
// window tap helper for the 3x3 reflect-101 convolution stream.
// No dependencies.
package c3r_pkg;

   // defaults for top-level parameters
   localparam int unsigned MAX_WIDTH_DEF  = 2048;
   localparam int unsigned COEF_FRAC_DEF  = 8;

   // fixed geometry and field widths
   localparam int unsigned KERNEL_SIZE = 3;
   localparam int unsigned NUM_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
   localparam int unsigned PIX_W       = 8;
   localparam int unsigned COEF_W      = 16;
   localparam int unsigned COEF_ROW_W  = KERNEL_SIZE * COEF_W;
   localparam int unsigned IMG_W_W     = 12;
   localparam int unsigned ROW_W       = 16;
   localparam int unsigned COL_OUT_W   = 11;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = COEF_ROW_W;

   // product and sum widths of the MAC
   localparam int unsigned PROD_W = PIX_W + 1 + COEF_W;
   localparam int unsigned ROWS_W = PROD_W + 2;
   localparam int unsigned SUM_W  = PROD_W + 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

   // register reset values
   localparam logic [IMG_W_W-1:0]    IMAGE_WIDTH_RST  = 12'd640;
   localparam logic [ROW_W-1:0]      IMAGE_HEIGHT_RST = 16'd480;
   localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST     = 48'd0;
   localparam logic [COEF_ROW_W-1:0] COEF_MIDDLE_RST  = 48'd16777216;
   localparam logic [COEF_ROW_W-1:0] COEF_BOTTOM_RST  = 48'd0;

   // input commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // one window column, index 0 is the top row
   typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] pix_col_type;
   // nine taps, index row*3 + column
   typedef logic [NUM_TAPS-1:0][PIX_W-1:0]    taps_type;
   typedef logic [NUM_TAPS-1:0][COEF_W-1:0]   coef_type;

   // position info carried alongside a result through the MAC
   typedef struct packed {
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 fe;
   } tag_type;

   // Gather taps from three columns; top_low takes the top row from the
   // bottom entry (reflection at the first image row).
   function automatic taps_type win_taps(input pix_col_type lft,
                                         input pix_col_type mid,
                                         input pix_col_type rgt,
                                         input logic        top_low);
      taps_type t;
      int unsigned src;
      t = '0;
      for (int unsigned r = 0; r < KERNEL_SIZE; r++) begin
         src = (r == 0 && top_low) ? KERNEL_SIZE - 1 : r;
         t[r*KERNEL_SIZE + 0] = lft[src];
         t[r*KERNEL_SIZE + 1] = mid[src];
         t[r*KERNEL_SIZE + 2] = rgt[src];
      end
      return t;
   endfunction

endpackage

@@ hw/rtl/conv3x3_reflect101_stream.sv @@
// conv3x3_reflect101_stream: top level of the streaming 3x3 convolution with
// reflect-101 borders. Uses c3r_pkg, c3r_line_mem, c3r_cell and c3r_mac.
//
//   channel | ports                                           | direction
//   --------+-------------------------------------------------+----------
//   req     | req_valid req_ready req_cmd req_pixel_in        | in
//   rsp     | rsp_valid rsp_ready rsp_pixel_out rsp_out_column| out
//           | rsp_out_row rsp_frame_end                       |
//   csr     | csr_we csr_index csr_wdata                      | in
//
// One beat per cycle on req while req_ready is high; a result passes the four
// MAC stages after issue. The last pixel of each row after the first makes two
// results and holds req_ready low until the second is issued. Line stores are
// read every cycle at the next beat's columns; each csr write holds req_ready
// low in the next cycle while reads refresh. Synchronous reset, no clearing pass.
// rsp back-pressure fills the four MAC stages before req_ready drops.
module conv3x3_reflect101_stream
   import c3r_pkg::*;
#(
   parameter int unsigned MAX_WIDTH      = MAX_WIDTH_DEF,
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic [COL_OUT_W-1:0]  rsp_out_column,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic                  rsp_frame_end,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // configuration registers
   logic [IMG_W_W-1:0]    img_w_ff;
   logic [ROW_W-1:0]      img_h_ff;
   logic [COEF_ROW_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic                  stale_ff;

   // position state
   logic [AW-1:0]    in_col_ff, in_col_in, pend_col_ff, pend_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, pend_row_ff, pend_row_in;
   logic             second_ff, second_in;

   // derived geometry and step decode
   logic [AW-1:0]    wlast, x, p, x_n, p_n, cl_n, cr_n;
   logic [ROW_W-1:0] hlast;
   logic             drain, acc, is_pix, pix_go, fl_go, lastp;

   // line store read data
   logic [PIX_W-1:0] a_cl, a_p, a_cr, a_x, b_cl, b_p, b_cr, b_x;

   // window cells
   pix_col_type c_q [KERNEL_SIZE];
   pix_col_type cell_in [KERNEL_SIZE];
   pix_col_type col_new, fl_l, fl_m, fl_r;

   // MAC issue
   coef_type coefs;
   taps_type mac_taps;
   tag_type  mac_tag, rsp_tag;
   logic     mac_valid, mac_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff    <= IMAGE_WIDTH_RST;
         img_h_ff    <= IMAGE_HEIGHT_RST;
         coef_top_ff <= COEF_TOP_RST;
         coef_mid_ff <= COEF_MIDDLE_RST;
         coef_bot_ff <= COEF_BOTTOM_RST;
         stale_ff    <= 1'b1;
      end else begin
         stale_ff <= csr_we;
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  img_w_ff    <= csr_wdata[IMG_W_W-1:0];
               REG_IMAGE_HEIGHT: img_h_ff    <= csr_wdata[ROW_W-1:0];
               REG_COEF_TOP:     coef_top_ff <= csr_wdata[COEF_ROW_W-1:0];
               REG_COEF_MIDDLE:  coef_mid_ff <= csr_wdata[COEF_ROW_W-1:0];
               REG_COEF_BOTTOM:  coef_bot_ff <= csr_wdata[COEF_ROW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // effective last column and last row
   always_comb begin
      if (img_w_ff < 12'd2) begin
         wlast = AW'(1);
      end else if (32'(img_w_ff) > 32'(MAX_WIDTH)) begin
         wlast = AW'(MAX_WIDTH - 1);
      end else begin
         wlast = AW'(img_w_ff - 12'd1);
      end
      hlast = (img_h_ff < 16'd2) ? 16'd1 : img_h_ff - 16'd1;
   end

   // coefficient unpack, left coefficient in the low bits
   always_comb begin
      for (int c = 0; c < KERNEL_SIZE; c++) begin
         coefs[c]                 = coef_top_ff[c*COEF_W +: COEF_W];
         coefs[KERNEL_SIZE + c]   = coef_mid_ff[c*COEF_W +: COEF_W];
         coefs[2*KERNEL_SIZE + c] = coef_bot_ff[c*COEF_W +: COEF_W];
      end
   end

   // step decode
   assign req_ready = mac_ready && !stale_ff && !second_ff;
   assign acc       = req_valid && req_ready;
   assign is_pix    = (req_cmd == CMD_PIXEL);
   assign drain     = (in_row_ff > hlast);
   assign pix_go    = acc && is_pix && !drain;
   assign fl_go     = acc && (req_cmd == CMD_FLUSH) && drain;
   assign x         = (in_col_ff > wlast) ? wlast : in_col_ff;
   assign p         = (pend_col_ff > wlast) ? wlast : pend_col_ff;
   assign lastp     = (p == wlast);

   // position update
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      pend_col_in = pend_col_ff;
      pend_row_in = pend_row_ff;
      if (pix_go) begin
         if (x == wlast) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 16'd1;
            if (in_row_ff >= hlast) begin
               pend_col_in = '0;
               pend_row_in = hlast;
            end
         end else begin
            in_col_in = x + AW'(1);
         end
      end
      if (fl_go) begin
         if (lastp) begin
            in_col_in   = '0;
            in_row_in   = '0;
            pend_col_in = '0;
            pend_row_in = '0;
         end else begin
            pend_col_in = p + AW'(1);
         end
      end
   end

   // second result of a row end is issued from second_ff, held until the MAC takes it
   always_comb begin
      if (second_ff) begin
         second_in = !mac_ready;
      end else begin
         second_in = pix_go && (in_row_ff != '0) && (x == wlast);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         pend_col_ff <= '0;
         pend_row_ff <= '0;
         second_ff   <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         pend_col_ff <= pend_col_in;
         pend_row_ff <= pend_row_in;
         second_ff   <= second_in;
      end
   end

   // read addresses for the next beat
   always_comb begin
      x_n  = (in_col_in > wlast) ? wlast : in_col_in;
      p_n  = (pend_col_in > wlast) ? wlast : pend_col_in;
      cl_n = (p_n == '0) ? AW'(1) : p_n - AW'(1);
      cr_n = (p_n == wlast) ? wlast - AW'(1) : p_n + AW'(1);
   end

   // line stores, two copies each for three flush reads
   c3r_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(AW), .DATA_W(PIX_W)) u_mem_a0 (
      .clock(clock), .we(pix_go), .waddr(x), .wdata(req_pixel_in),
      .raddr0(cl_n), .raddr1(p_n), .rdata0(a_cl), .rdata1(a_p));
   c3r_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(AW), .DATA_W(PIX_W)) u_mem_a1 (
      .clock(clock), .we(pix_go), .waddr(x), .wdata(req_pixel_in),
      .raddr0(cr_n), .raddr1(x_n), .rdata0(a_cr), .rdata1(a_x));
   c3r_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(AW), .DATA_W(PIX_W)) u_mem_b0 (
      .clock(clock), .we(pix_go), .waddr(x), .wdata(a_x),
      .raddr0(cl_n), .raddr1(p_n), .rdata0(b_cl), .rdata1(b_p));
   c3r_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(AW), .DATA_W(PIX_W)) u_mem_b1 (
      .clock(clock), .we(pix_go), .waddr(x), .wdata(a_x),
      .raddr0(cr_n), .raddr1(x_n), .rdata0(b_cr), .rdata1(b_x));

   // window: new column enters cell 2 and moves left
   assign col_new[0] = b_x;
   assign col_new[1] = a_x;
   assign col_new[2] = req_pixel_in;
   assign cell_in[2] = col_new;
   assign cell_in[1] = c_q[2];
   assign cell_in[0] = c_q[1];

   for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
      c3r_cell u_cell (
         .clock(clock), .reset(reset), .shift(pix_go),
         .col_in(cell_in[k]), .col_out(c_q[k]));
   end

   // flush columns: bottom row reflects to the row above
   assign fl_l = {b_cl, a_cl, b_cl};
   assign fl_m = {b_p, a_p, b_p};
   assign fl_r = {b_cr, a_cr, b_cr};

   // MAC issue select
   always_comb begin
      if (second_ff) begin
         mac_taps = win_taps(c_q[1], c_q[2], c_q[1], in_row_ff == 16'd2);
         mac_tag  = '{col: COL_OUT_W'(wlast), row: in_row_ff - 16'd2, fe: 1'b0};
      end else if (!is_pix) begin
         mac_taps = win_taps(fl_l, fl_m, fl_r, 1'b0);
         mac_tag  = '{col: COL_OUT_W'(p), row: pend_row_ff, fe: lastp};
      end else begin
         mac_taps = win_taps((x == AW'(1)) ? col_new : c_q[1], c_q[2], col_new,
                             in_row_ff == 16'd1);
         mac_tag  = '{col: COL_OUT_W'(x - AW'(1)), row: in_row_ff - 16'd1, fe: 1'b0};
      end
   end

   assign mac_valid = second_ff
                    || (pix_go && (in_row_ff != '0) && (x != '0))
                    || fl_go;

   c3r_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
      .clock(clock), .reset(reset),
      .in_valid(mac_valid), .in_ready(mac_ready),
      .in_taps(mac_taps), .in_tag(mac_tag), .coefs(coefs),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_pixel(rsp_pixel_out), .out_tag(rsp_tag));

   assign rsp_out_column = rsp_tag.col;
   assign rsp_out_row    = rsp_tag.row;
   assign rsp_frame_end  = rsp_tag.fe;

   // checks
   a_second_blocks: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !req_ready)
      else $error("req taken while row-end result pending");

   a_csr_refresh: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("req taken before line store reads refreshed");

   a_one_issue: assert property (@(posedge clock) disable iff (reset)
      $onehot0({pix_go, fl_go, second_ff}))
      else $error("more than one issue source in a cycle");

endmodule

@@ hw/rtl/c3r_line_mem.sv @@
// c3r_line_mem: one line store, one write port and two registered read ports.
// A read of the address written in the same cycle returns the new data.
// Depends on nothing.
module c3r_line_mem #(
   parameter int unsigned DEPTH  = 2048,
   parameter int unsigned ADDR_W = 11,
   parameter int unsigned DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr0,
   input  logic [ADDR_W-1:0] raddr1,
   output logic [DATA_W-1:0] rdata0,
   output logic [DATA_W-1:0] rdata1
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rdata0_ff;
   logic [DATA_W-1:0] rdata1_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   // read ports, write-first on a colliding address
   always_ff @(posedge clock) begin
      rdata0_ff <= (we && waddr == raddr0) ? wdata : store_ff[raddr0];
      rdata1_ff <= (we && waddr == raddr1) ? wdata : store_ff[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

@@ hw/rtl/c3r_cell.sv @@
// c3r_cell: one column of the 3x3 window; takes its neighbor's column on shift.
// Depends on c3r_pkg.
module c3r_cell
   import c3r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        shift,
   input  pix_col_type col_in,
   output pix_col_type col_out
);

   pix_col_type col_ff;
   pix_col_type col_in_nxt;

   assign col_in_nxt = shift ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_nxt;
      end
   end

   assign col_out = col_ff;

endmodule

@@ hw/rtl/c3r_mac.sv @@
// c3r_mac: four-stage multiply, sum, round-half-even and saturate pipeline
// with per-stage valid and a back-pressure chain from the output.
// Depends on c3r_pkg.
module c3r_mac
   import c3r_pkg::*;
#(
   parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  taps_type         in_taps,
   input  tag_type          in_tag,
   input  coef_type         coefs,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [PIX_W-1:0] out_pixel,
   output tag_type          out_tag
);

   localparam int unsigned NSTG = 4;
   localparam int unsigned QW   = SUM_W - COEF_FRAC_BITS;
   localparam logic [COEF_FRAC_BITS-1:0] HALF = {1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG:0]   rdy;
   tag_type         tag_ff [NSTG];

   logic signed [PROD_W-1:0] prod_ff [NUM_TAPS];
   logic signed [PROD_W-1:0] prod_in [NUM_TAPS];
   logic signed [ROWS_W-1:0] rsum_ff [KERNEL_SIZE];
   logic signed [ROWS_W-1:0] rsum_in [KERNEL_SIZE];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [PIX_W-1:0]         pix_ff, pix_in;

   logic [QW-1:0]             q;
   logic [COEF_FRAC_BITS-1:0] rem;
   logic [QW:0]               qr;
   logic                      up;

   // back-pressure chain, output end first
   always_comb begin
      rdy[NSTG] = out_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < NSTG; k++) begin
         if (k == 0) begin
            v_in[k] = rdy[k] ? in_valid : v_ff[k];
         end else begin
            v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
         end
      end
   end

   assign in_ready = rdy[0];

   // stage 1: nine products
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         prod_in[k] = $signed({1'b0, in_taps[k]}) * $signed(coefs[k]);
      end
   end

   // stage 2: row sums
   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         rsum_in[r] = ROWS_W'(prod_ff[r*KERNEL_SIZE])
                    + ROWS_W'(prod_ff[r*KERNEL_SIZE + 1])
                    + ROWS_W'(prod_ff[r*KERNEL_SIZE + 2]);
      end
   end

   // stage 3: total
   assign sum_in = SUM_W'(rsum_ff[0]) + SUM_W'(rsum_ff[1]) + SUM_W'(rsum_ff[2]);

   // stage 4: round half to even, saturate to 0..255
   always_comb begin
      q   = sum_ff[SUM_W-1:COEF_FRAC_BITS];
      rem = sum_ff[COEF_FRAC_BITS-1:0];
      up  = (rem > HALF) || (rem == HALF && q[0]);
      qr  = {1'b0, q} + (QW+1)'(up);
      if (sum_ff <= 0) begin
         pix_in = '0;
      end else if (qr > (QW+1)'(255)) begin
         pix_in = 8'd255;
      end else begin
         pix_in = qr[PIX_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // payload registers, loaded whenever a stage may take a beat
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prod_ff   <= prod_in;
         tag_ff[0] <= in_tag;
      end
      if (rdy[1]) begin
         rsum_ff   <= rsum_in;
         tag_ff[1] <= tag_ff[0];
      end
      if (rdy[2]) begin
         sum_ff    <= sum_in;
         tag_ff[2] <= tag_ff[1];
      end
      if (rdy[3]) begin
         pix_ff    <= pix_in;
         tag_ff[3] <= tag_ff[2];
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_pixel = pix_ff;
   assign out_tag   = tag_ff[NSTG-1];

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for the 3x3 reflect-101 convolution stream.
// Depends on c3r_pkg and conv3x3_reflect101_stream; predicts every result beat.
`timescale 1ns / 1ps

module tb;
   import c3r_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]     pix;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 fe;
   } pixel_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd = CMD_PIXEL;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic [COL_OUT_W-1:0]  rsp_out_column;
   logic [ROW_W-1:0]      rsp_out_row;
   logic                  rsp_frame_end;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   conv3x3_reflect101_stream i_dut (.*);

   // clock, period 4 ns
   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [PIX_W-1:0]      line_a [MAX_WIDTH_DEF];
   logic [PIX_W-1:0]      line_b [MAX_WIDTH_DEF];
   logic [PIX_W-1:0]      win [3][3];   // [row][col], col 2 newest
   int unsigned           in_col, in_row, pend_col, pend_row;
   logic [IMG_W_W-1:0]    width_reg;
   logic [ROW_W-1:0]      height_reg;
   logic [COEF_ROW_W-1:0] coef_reg [3];

   pixel_result_t expected_q[$];
   int unsigned   errors = 0;
   int unsigned   beats_sent = 0;
   int unsigned   results_seen = 0;
   int unsigned   frames_done = 0;
   int unsigned   send_idle = 7;
   int unsigned   recv_idle = 70;

   function automatic int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg < 2) ? 2 : height_reg;
   endfunction

   // sum of products, round half to even, clamp to 0..255
   function automatic logic [PIX_W-1:0] filter_taps(input logic [PIX_W-1:0] t [3][3]);
      longint           acc, q, rem;
      logic signed [15:0] k;
      acc = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) begin
            k = coef_reg[r][16*c +: 16];
            acc += longint'(t[r][c]) * longint'(k);
         end
      if (acc <= 0) return '0;
      q = acc >>> 8;
      rem = acc & 255;
      if (rem > 128 || (rem == 128 && q[0])) q++;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   function automatic logic [PIX_W-1:0] filter_window(input int unsigned top,
      input int unsigned cl, input int unsigned cm, input int unsigned cr);
      logic [PIX_W-1:0] t [3][3];
      int unsigned      src;
      for (int r = 0; r < 3; r++) begin
         src = (r == 0) ? top : r;
         t[r][0] = win[src][cl];
         t[r][1] = win[src][cm];
         t[r][2] = win[src][cr];
      end
      return filter_taps(t);
   endfunction

   task automatic push_result(input logic [PIX_W-1:0] v, input int unsigned col,
                              input int unsigned row, input logic fe);
      pixel_result_t e;
      e.pix = v;
      e.col = col[COL_OUT_W-1:0];
      e.row = row[ROW_W-1:0];
      e.fe  = fe;
      expected_q.push_back(e);
   endtask

   // advance the predictor by one accepted beat
   task automatic conv_predict(input logic cmd, input logic [PIX_W-1:0] pix);
      int unsigned      w, h, x, y, top, p, cl, cr;
      logic             lastc;
      logic [PIX_W-1:0] t [3][3];
      w = eff_width();
      h = eff_height();
      if (cmd == CMD_PIXEL) begin
         if (in_row >= h) return;  // pixel while draining
         x = (in_col > w - 1) ? w - 1 : in_col;
         y = in_row;
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = line_b[x];
         win[1][2] = line_a[x];
         win[2][2] = pix;
         line_b[x] = line_a[x];
         line_a[x] = pix;
         if (y >= 1) begin
            top = (y == 1) ? 2 : 0;
            if (x >= 1)
               push_result(filter_window(top, (x == 1) ? 2 : 0, 1, 2), x - 1, y - 1, 1'b0);
            if (x == w - 1)
               push_result(filter_window(top, 1, 2, 1), w - 1, y - 1, 1'b0);
         end
         if (x == w - 1) begin
            in_col = 0;
            in_row = y + 1;
            if (in_row >= h) begin
               pend_col = 0;
               pend_row = h - 1;
            end
         end else begin
            in_col = x + 1;
         end
      end else begin
         if (in_row < h) return;  // flush while not draining
         p = (pend_col > w - 1) ? w - 1 : pend_col;
         lastc = (p == w - 1);
         cl = (p == 0) ? 1 : p - 1;
         cr = lastc ? w - 2 : p + 1;
         // bottom row reflects to the row above
         t[0][0] = line_b[cl]; t[0][1] = line_b[p]; t[0][2] = line_b[cr];
         t[1][0] = line_a[cl]; t[1][1] = line_a[p]; t[1][2] = line_a[cr];
         t[2][0] = line_b[cl]; t[2][1] = line_b[p]; t[2][2] = line_b[cr];
         push_result(filter_taps(t), p, pend_row, lastc);
         if (lastc) begin
            in_row = 0; in_col = 0; pend_col = 0; pend_row = 0;
            frames_done++;
         end else begin
            pend_col = p + 1;
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      pixel_result_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%t unexpected beat: pix=%0d col=%0d row=%0d fe=%0b", $realtime,
                     rsp_pixel_out, rsp_out_column, rsp_out_row, rsp_frame_end);
         end else begin
            e = expected_q.pop_front();
            if (rsp_pixel_out !== e.pix || rsp_out_column !== e.col ||
                rsp_out_row !== e.row || rsp_frame_end !== e.fe) begin
               errors++;
               $display("%t mismatch: expected pix=%0d col=%0d row=%0d fe=%0b", $realtime,
                        e.pix, e.col, e.row, e.fe);
               $display("%t           actual   pix=%0d col=%0d row=%0d fe=%0b", $realtime,
                        rsp_pixel_out, rsp_out_column, rsp_out_row, rsp_frame_end);
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // one beat on req; called and returns at a falling edge
   task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] pix);
      while ($urandom_range(99) < send_idle) @(negedge clock);
      req_valid    = 1'b1;
      req_cmd      = cmd;
      req_pixel_in = pix;
      do @(posedge clock); while (!req_ready);
      conv_predict(cmd, pix);
      beats_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = d;
      case (idx)
         REG_IMAGE_WIDTH:  width_reg   = d[IMG_W_W-1:0];
         REG_IMAGE_HEIGHT: height_reg  = d[ROW_W-1:0];
         REG_COEF_TOP:     coef_reg[0] = d;
         REG_COEF_MIDDLE:  coef_reg[1] = d;
         REG_COEF_BOTTOM:  coef_reg[2] = d;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic set_kernel(input logic [COEF_ROW_W-1:0] t, input logic [COEF_ROW_W-1:0] m,
                             input logic [COEF_ROW_W-1:0] b);
      write_reg(REG_COEF_TOP, t);
      write_reg(REG_COEF_MIDDLE, m);
      write_reg(REG_COEF_BOTTOM, b);
   endtask

   // random kernel row: mostly moderate weights, sometimes any 48 bits
   function automatic logic [COEF_ROW_W-1:0] rand_coef_row();
      logic [COEF_ROW_W-1:0] v;
      if ($urandom_range(3) == 0) return COEF_ROW_W'({$urandom, $urandom});
      for (int c = 0; c < 3; c++) v[16*c +: 16] = 16'($urandom_range(600) - 300);
      return v;
   endfunction

   // whole frame at the current geometry; noise adds ignored beats
   task automatic run_frame(input bit noise);
      int unsigned w, h;
      w = eff_width();
      h = eff_height();
      for (int unsigned y = 0; y < h; y++)
         for (int unsigned x = 0; x < w; x++) begin
            if (noise && $urandom_range(19) == 0) send_beat(CMD_FLUSH, 8'($urandom));
            send_beat(CMD_PIXEL, 8'($urandom));
         end
      if (noise) send_beat(CMD_PIXEL, 8'($urandom));
      for (int unsigned p = 0; p < w; p++) send_beat(CMD_FLUSH, 8'($urandom));
   endtask

   task automatic test_identity_smallest();
      set_geometry(2, 2);
      set_kernel(COEF_TOP_RST, COEF_MIDDLE_RST, COEF_BOTTOM_RST);
      run_frame(0);
      wait_idle();
   endtask

   task automatic test_saturation();
      set_geometry(3, 2);
      set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
      run_frame(0);
      wait_idle();
      set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      run_frame(0);
      wait_idle();
   endtask

   // half weight on the centre: odd pixels land on a tie
   task automatic test_round_half_even();
      set_geometry(2, 2);
      set_kernel('0, 48'h0000_0080_0000, '0);
      run_frame(0);
      wait_idle();
   endtask

   // flush at frame start, stray flushes and a pixel while draining
   task automatic test_ignored_beats();
      set_kernel(rand_coef_row(), rand_coef_row(), rand_coef_row());
      send_beat(CMD_FLUSH, 8'hFF);
      run_frame(1);
      wait_idle();
   endtask

   // width 1 and height 0 act as 2
   task automatic test_geometry_clamps();
      set_geometry(1, 0);
      run_frame(0);
      wait_idle();
   endtask

   // tallest frame cut short by lowering the height mid-frame
   task automatic test_height_cut();
      set_geometry(3, 65535);
      for (int i = 0; i < 9; i++) send_beat(CMD_PIXEL, 8'($urandom));
      wait_idle();
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(2));
      for (int i = 0; i < 3; i++) send_beat(CMD_FLUSH, 8'($urandom));
      wait_idle();
   endtask

   task automatic test_random_frames();
      while (beats_sent < 1050) begin
         if (beats_sent < 350) begin
            send_idle = 7;  recv_idle = 70;
         end else if (beats_sent < 700) begin
            send_idle = 70; recv_idle = 7;
         end else begin
            send_idle = 0;  recv_idle = 0;
         end
         set_geometry($urandom_range(2, 10), $urandom_range(2, 5));
         set_kernel(rand_coef_row(), rand_coef_row(), rand_coef_row());
         run_frame($urandom_range(3) == 0);
         wait_idle();
      end
   endtask

   initial begin
      in_col = 0; in_row = 0; pend_col = 0; pend_row = 0;
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      coef_reg[0] = COEF_TOP_RST;
      coef_reg[1] = COEF_MIDDLE_RST;
      coef_reg[2] = COEF_BOTTOM_RST;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win[r][c] = '0;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         line_a[i] = '0;
         line_b[i] = '0;
      end
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_identity_smallest();
      test_saturation();
      test_round_half_even();
      test_ignored_beats();
      test_geometry_clamps();
      test_height_cut();
      test_random_frames();

      $display("Covered %0d req beats and %0d result beats over %0d frames,", beats_sent,
               results_seen, frames_done);
      $display("widths 2..10, clamped geometry, saturation, ties and ignored beats.");
      if (errors == 0)
         $display("[conv3x3_reflect101_stream] OK");
      else
         $display("[conv3x3_reflect101_stream] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("[conv3x3_reflect101_stream] ERROR");
      $finish;
   end

endmodule
